### hdl/coordinate_id_bidirectional_map_unit_assert.svh
// Assertion macros for the coordinate/id map unit.
// Expects clk and rst in the scope where the macros are used.
`ifndef COORDINATE_ID_BIDIRECTIONAL_MAP_UNIT_ASSERT_SVH
`define COORDINATE_ID_BIDIRECTIONAL_MAP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CIDM_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define CIDM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CIDM_CHECK(lbl, expr, msg)
`define CIDM_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/cidm_pkg.sv
// Shared types and constants of the coordinate/id map unit.
// No dependencies.
`timescale 1ns / 1ps
package cidm_pkg;
  localparam int NUM_DIMS = 4;
  localparam int MAX_DIMS = 4;
  localparam int DIM_IDX_W = 2;
  localparam int COORD_W = 10;
  localparam int ID_W = 8;
  localparam int ID_OUT_W = 9;
  localparam int LIMIT_W = 11;
  localparam int DIMS_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int CMD_W = 2;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W = OUT_DATA_W - 1 - ID_OUT_W - NUM_DIMS * COORD_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [DIMS_W-1:0] NUM_DIMS_RESET = 3'd4;
  localparam logic [ID_OUT_W-1:0] NONE_ID = 9'h1FF;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_LIMIT_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_LIMIT_LAST = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 2'd0,
    CMD_FIND_ID     = 2'd1,
    CMD_FIND_COORDS = 2'd2
  } cmd_t;

  typedef logic [NUM_DIMS-1:0][COORD_W-1:0] coords_t;

  typedef struct packed {
    cmd_t             cmd;
    coords_t          coords;
    logic [ID_W-1:0]  uid;
    logic             loc_hit;
  } op_t;

  typedef struct packed {
    logic              busy;
    logic [DIMS_W-1:0] dims;
  } cfg_status_t;
endpackage

### hdl/cidm_cfg.sv
// Configuration registers and stride sequencer of the coordinate/id map unit.
// Depends on cidm_pkg.
`timescale 1ns / 1ps
module cidm_cfg #(
  parameter int LOC_DEPTH = 1024,
  localparam int STRIDE_W = $clog2(LOC_DEPTH + 1)
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic [cidm_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [cidm_pkg::CFG_DATA_W-1:0]              cfg_data,
  output cidm_pkg::cfg_status_t                        status,
  output logic [cidm_pkg::NUM_DIMS-1:0][STRIDE_W-1:0]  strides,
  output logic [STRIDE_W-1:0]                          cap
);
  import cidm_pkg::*;

  localparam int PROD_W = STRIDE_W + LIMIT_W;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                              state;
  logic [DIMS_W-1:0]                   num_dims;
  logic [NUM_DIMS-1:0][LIMIT_W-1:0]    dim_limit;
  logic [DIM_IDX_W-1:0]                step;
  logic [STRIDE_W-1:0]                 acc;
  logic [STRIDE_W-1:0]                 acc_next;
  logic [PROD_W-1:0]                   prod;
  logic [DIMS_W-1:0]                   dims;
  logic                                in_use;

  always_comb begin
    if (num_dims == '0) begin
      dims = DIMS_W'(1);
    end else if (num_dims > DIMS_W'(MAX_DIMS)) begin
      dims = DIMS_W'(MAX_DIMS);
    end else begin
      dims = num_dims;
    end
  end

  // saturate at the table depth: any larger stride already lands out of range
  assign prod = PROD_W'(acc) * PROD_W'(dim_limit[step]);
  assign acc_next = (prod > PROD_W'(LOC_DEPTH)) ? STRIDE_W'(LOC_DEPTH) : prod[STRIDE_W-1:0];
  assign in_use = DIMS_W'(step) < dims;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      step      <= DIM_IDX_W'(NUM_DIMS - 1);
      acc       <= STRIDE_W'(1);
      num_dims  <= NUM_DIMS_RESET;
      dim_limit <= {NUM_DIMS{LIMIT_W'(1)}};
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_DIMS) begin
        num_dims <= cfg_data[DIMS_W-1:0];
      end else if (cfg_index >= CFG_DIM_LIMIT_0 && cfg_index <= CFG_DIM_LIMIT_LAST) begin
        dim_limit[DIM_IDX_W'(cfg_index - CFG_DIM_LIMIT_0)] <= cfg_data;
      end
      state <= ST_RUN;
      step  <= DIM_IDX_W'(NUM_DIMS - 1);
      acc   <= STRIDE_W'(1);
    end else if (state == ST_RUN) begin
      if (in_use) begin
        strides[step] <= acc;
        acc           <= acc_next;
      end else begin
        strides[step] <= '0;
      end
      if (step == '0) begin
        state <= ST_IDLE;
        cap   <= in_use ? acc_next : acc;
      end else begin
        step <= step - DIM_IDX_W'(1);
      end
    end
  end

  assign status.busy = (state == ST_RUN);
  assign status.dims = dims;
endmodule

### hdl/cidm_front.sv
// Front end: accepts items, forms the flat index and classifies it against capacity.
// Depends on cidm_pkg.
`timescale 1ns / 1ps
module cidm_front #(
  parameter int LOC_DEPTH = 1024,
  localparam int STRIDE_W = $clog2(LOC_DEPTH + 1),
  localparam int LOC_AW = $clog2(LOC_DEPTH)
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         hold,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  input  logic [cidm_pkg::IN_DATA_W-1:0]               s_tdata,  // coord_0..coord_3, user_id
  input  logic [cidm_pkg::CMD_W-1:0]                   s_tuser,  // command
  input  logic [cidm_pkg::NUM_DIMS-1:0][STRIDE_W-1:0]  strides,
  input  logic [STRIDE_W-1:0]                          cap,
  input  logic                                         q_full,
  output logic                                         push,
  output cidm_pkg::op_t                                push_op,
  output logic [LOC_AW-1:0]                            push_addr
);
  import cidm_pkg::*;

  localparam int PROD_W = STRIDE_W + COORD_W;
  localparam int SUM_W = PROD_W + 2;

  logic                              a_valid;
  cmd_t                              a_cmd;
  coords_t                           a_coords;
  logic [ID_W-1:0]                   a_uid;
  logic [NUM_DIMS-1:0][PROD_W-1:0]   a_prod;
  coords_t                           in_coords;
  logic [SUM_W-1:0]                  sum;

  assign in_coords = coords_t'(s_tdata[NUM_DIMS*COORD_W-1:0]);
  assign s_tready = !hold && (!a_valid || push);
  assign push = a_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      a_valid  <= 1'b1;
      a_cmd    <= cmd_t'(s_tuser);
      a_coords <= in_coords;
      a_uid    <= s_tdata[NUM_DIMS*COORD_W +: ID_W];
      for (int i = 0; i < NUM_DIMS; i++) begin
        a_prod[i] <= PROD_W'(in_coords[i]) * PROD_W'(strides[i]);
      end
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      sum = sum + SUM_W'(a_prod[i]);
    end
  end

  assign push_op.cmd     = a_cmd;
  assign push_op.coords  = a_coords;
  assign push_op.uid     = a_uid;
  assign push_op.loc_hit = sum < SUM_W'(cap);
  assign push_addr       = sum[LOC_AW-1:0];
endmodule

### hdl/cidm_queue.sv
// Two-entry queue between the front end and the table back end.
// Depends on cidm_pkg.
`timescale 1ns / 1ps
module cidm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] data
);
  import cidm_pkg::*;

  logic [QUEUE_DEPTH-1:0][WIDTH-1:0] mem;
  logic [QPTR_W-1:0]                 wr_ptr;
  logic [QPTR_W-1:0]                 rd_ptr;
  logic [QCNT_W-1:0]                 count;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign data    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end
endmodule

### hdl/cidm_back.sv
// Back end: location and id tables, clearing pass, result formation and output register.
// Depends on cidm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "coordinate_id_bidirectional_map_unit_assert.svh"
module cidm_back #(
  parameter int LOC_DEPTH = 1024,
  parameter int ID_DEPTH = 256,
  localparam int LOC_AW = $clog2(LOC_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  cidm_pkg::op_t                   q_op,
  input  logic [LOC_AW-1:0]               q_addr,
  output logic                            pop,
  input  logic [cidm_pkg::DIMS_W-1:0]     dims,
  output logic                            clearing,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cidm_pkg::OUT_DATA_W-1:0] m_tdata  // found, id_out, loc_out_0..loc_out_3
);
  import cidm_pkg::*;

  localparam int ID_AW = $clog2(ID_DEPTH);
  localparam int CLR_DEPTH = (LOC_DEPTH > ID_DEPTH) ? LOC_DEPTH : ID_DEPTH;
  localparam int CLR_W = $clog2(CLR_DEPTH);

  typedef struct packed {
    logic    valid;
    coords_t coords;
  } id_entry_t;

  logic [ID_OUT_W-1:0]   loc_mem [LOC_DEPTH];
  id_entry_t             id_mem [ID_DEPTH];

  logic                  clr_active;
  logic [CLR_W-1:0]      clr_addr;

  logic                  loc_we;
  logic [LOC_AW-1:0]     loc_wa;
  logic [ID_OUT_W-1:0]   loc_wd;
  logic                  loc_re;
  logic [ID_OUT_W-1:0]   loc_rd;
  logic                  id_we;
  logic [ID_AW-1:0]      id_wa;
  id_entry_t             id_wd;
  logic                  id_re;
  id_entry_t             id_rd;

  logic                  q_uid_ok;
  logic                  r_valid;
  op_t                   r_op;
  logic                  r_uid_ok;
  logic                  r_adv;

  logic                  res_found;
  logic [ID_OUT_W-1:0]   res_id;
  coords_t               res_loc;
  coords_t               masked;

  assign clearing = clr_active;
  assign q_uid_ok = int'(q_op.uid) < ID_DEPTH;
  assign r_adv    = r_valid && (!m_tvalid || m_tready);
  assign pop      = q_valid && !clr_active && (!r_valid || r_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == CLR_W'(CLR_DEPTH - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + CLR_W'(1);
      end
    end
  end

  always_comb begin
    if (clr_active) begin
      loc_we = int'(clr_addr) < LOC_DEPTH;
      loc_wa = clr_addr[LOC_AW-1:0];
      loc_wd = NONE_ID;
      id_we  = int'(clr_addr) < ID_DEPTH;
      id_wa  = clr_addr[ID_AW-1:0];
      id_wd  = '0;
    end else begin
      loc_we = pop && (q_op.cmd == CMD_INSERT) && q_op.loc_hit;
      loc_wa = q_addr;
      loc_wd = {1'b0, q_op.uid};
      id_we  = pop && (q_op.cmd == CMD_INSERT) && q_uid_ok;
      id_wa  = ID_AW'(q_op.uid);
      id_wd  = '{valid: 1'b1, coords: q_op.coords};
    end
  end

  assign loc_re = pop && (q_op.cmd == CMD_FIND_ID) && q_op.loc_hit;
  assign id_re  = pop && (q_op.cmd == CMD_FIND_COORDS) && q_uid_ok;

  always_ff @(posedge clk) begin
    if (loc_we) begin
      loc_mem[loc_wa] <= loc_wd;
    end
    if (loc_re) begin
      loc_rd <= loc_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[id_wa] <= id_wd;
    end
    if (id_re) begin
      id_rd <= id_mem[ID_AW'(q_op.uid)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (pop) begin
      r_valid  <= 1'b1;
      r_op     <= q_op;
      r_uid_ok <= q_uid_ok;
    end else if (r_adv) begin
      r_valid <= 1'b0;
    end
  end

  always_comb begin
    res_found = 1'b0;
    res_id    = NONE_ID;
    res_loc   = '0;
    masked    = (r_op.cmd == CMD_FIND_COORDS) ? id_rd.coords : r_op.coords;
    for (int i = 0; i < NUM_DIMS; i++) begin
      if (DIMS_W'(i) >= dims) begin
        masked[i] = '0;
      end
    end
    case (r_op.cmd)
      CMD_INSERT: begin
        res_found = r_op.loc_hit;
        if (r_op.loc_hit) begin
          res_id = {1'b0, r_op.uid};
        end
        if (r_uid_ok) begin
          res_loc = masked;
        end
      end
      CMD_FIND_ID: begin
        if (r_op.loc_hit) begin
          res_id    = loc_rd;
          res_found = (loc_rd != NONE_ID);
        end
      end
      CMD_FIND_COORDS: begin
        if (r_uid_ok && id_rd.valid) begin
          res_found = 1'b1;
          res_loc   = masked;
        end
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (r_adv) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {OUT_PAD_W'(0), res_loc, res_id, res_found};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `CIDM_CHECK(a_loc_single_access, !(loc_we && loc_re), "location table written and read at once")
  `CIDM_CHECK(a_id_single_access, !(id_we && id_re), "id table written and read at once")
  `CIDM_CHECK_NEXT(a_result_moves, r_valid && !m_tvalid, m_tvalid, "result not moved to output")
endmodule

### hdl/coordinate_id_bidirectional_map_unit.sv
// Path: an accepted item passes the front-end register, the queue, the table read stage
// and the output register to m_tdata. Throughput: one item per cycle while m_tready is
// high and s_tready is not held low, set by one access per item to each single-port table.
// Reset: a clearing pass empties both tables; s_tready stays low until it ends. Each
// configuration write recomputes the strides, one multiply per dimension, with s_tready low.
`timescale 1ns / 1ps
module coordinate_id_bidirectional_map_unit #(
  parameter int LOC_DEPTH = 1024,
  parameter int ID_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cidm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cidm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cidm_pkg::IN_DATA_W-1:0]   s_tdata,   // coord_0..coord_3, user_id
  input  logic [cidm_pkg::CMD_W-1:0]       s_tuser,   // command
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cidm_pkg::OUT_DATA_W-1:0]  m_tdata    // found, id_out, loc_out_0..loc_out_3
);
  import cidm_pkg::*;

  localparam int STRIDE_W = $clog2(LOC_DEPTH + 1);
  localparam int LOC_AW = $clog2(LOC_DEPTH);
  localparam int Q_W = $bits(op_t) + LOC_AW;

  cfg_status_t                          status;
  logic [NUM_DIMS-1:0][STRIDE_W-1:0]    strides;
  logic [STRIDE_W-1:0]                  cap;
  logic                                 clearing;
  logic                                 hold;
  logic                                 push;
  op_t                                  push_op;
  logic [LOC_AW-1:0]                    push_addr;
  logic                                 q_full;
  logic                                 q_valid;
  logic [Q_W-1:0]                       q_data;
  logic                                 pop;
  op_t                                  q_op;
  logic [LOC_AW-1:0]                    q_addr;

  assign hold = status.busy || clearing;
  assign q_op   = op_t'(q_data[Q_W-1:LOC_AW]);
  assign q_addr = q_data[LOC_AW-1:0];

  cidm_cfg #(.LOC_DEPTH(LOC_DEPTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .strides   (strides),
    .cap       (cap)
  );

  cidm_front #(.LOC_DEPTH(LOC_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (hold),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .strides   (strides),
    .cap       (cap),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op),
    .push_addr (push_addr)
  );

  cidm_queue #(.WIDTH(Q_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_op, push_addr}),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .data      (q_data)
  );

  cidm_back #(.LOC_DEPTH(LOC_DEPTH), .ID_DEPTH(ID_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_addr    (q_addr),
    .pop       (pop),
    .dims      (status.dims),
    .clearing  (clearing),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );
endmodule

### test/coordinate_id_bidirectional_map_unit_checker.sv
// Checker for the coordinate/id map unit: predicts one reply per accepted item
// and compares it with the reply stream. Depends on cidm_pkg.
`timescale 1ns / 1ps
module coordinate_id_bidirectional_map_unit_checker #(
  parameter int LOC_DEPTH = 1024,
  parameter int ID_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cidm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cidm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [cidm_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [cidm_pkg::CMD_W-1:0]      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [cidm_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                              backlog,
  output int                              errors
);
  import cidm_pkg::*;

  typedef struct packed {
    logic                found;
    logic [ID_OUT_W-1:0] id_out;
    coords_t             locs;
  } reply_t;

  logic [ID_OUT_W-1:0] loc_table [LOC_DEPTH];
  logic                id_valid [ID_DEPTH];
  coords_t             id_coords [ID_DEPTH];
  logic [DIMS_W-1:0]   dims_reg;
  logic [LIMIT_W-1:0]  limit_reg [NUM_DIMS];
  reply_t              due_replies [$];
  int                  fail_count = 0;

  assign errors = fail_count;

  function automatic reply_t map_item(input logic [CMD_W-1:0] cmd, input coords_t crd,
                                      input logic [ID_W-1:0] uid);
    reply_t          r;
    int              dims;
    int              i;
    longint unsigned flat;
    longint unsigned span;
    dims = int'(dims_reg);
    if (dims < 1) dims = 1;
    if (dims > MAX_DIMS) dims = MAX_DIMS;
    if (dims > NUM_DIMS) dims = NUM_DIMS;
    flat = 0;
    span = 1;
    for (i = dims - 1; i >= 0; i--) begin
      flat += crd[i] * span;
      span *= limit_reg[i];
    end
    if (span > LOC_DEPTH) span = LOC_DEPTH;
    r.found = 1'b0;
    r.id_out = NONE_ID;
    r.locs = '0;
    case (cmd)
      CMD_INSERT: begin
        if (flat < span) begin
          loc_table[flat] = {1'b0, uid};
          r.found = 1'b1;
          r.id_out = {1'b0, uid};
        end
        if (uid < ID_DEPTH) begin
          id_valid[uid] = 1'b1;
          id_coords[uid] = crd;
          for (i = 0; i < dims; i++) r.locs[i] = crd[i];
        end
      end
      CMD_FIND_ID: begin
        if (flat < span) begin
          r.id_out = loc_table[flat];
          r.found = (r.id_out != NONE_ID);
        end
      end
      CMD_FIND_COORDS: begin
        if (uid < ID_DEPTH && id_valid[uid]) begin
          r.found = 1'b1;
          for (i = 0; i < dims; i++) r.locs[i] = id_coords[uid][i];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_reply(input reply_t want, input logic [OUT_DATA_W-1:0] word);
    reply_t got;
    int     i;
    got.found = word[0];
    got.id_out = word[ID_OUT_W:1];
    got.locs = word[1+ID_OUT_W +: NUM_DIMS*COORD_W];
    if (got.found !== want.found) begin
      $display("%0t found: expected %0d, got %0d", $time, want.found, got.found);
      fail_count++;
    end
    if (got.id_out !== want.id_out) begin
      $display("%0t id_out: expected %0d, got %0d", $time, $signed(want.id_out),
               $signed(got.id_out));
      fail_count++;
    end
    for (i = 0; i < NUM_DIMS; i++) begin
      if (got.locs[i] !== want.locs[i]) begin
        $display("%0t loc_out_%0d: expected %0d, got %0d", $time, i, want.locs[i],
                 got.locs[i]);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOC_DEPTH; i++) loc_table[i] = NONE_ID;
      for (int i = 0; i < ID_DEPTH; i++) begin
        id_valid[i] = 1'b0;
        id_coords[i] = '0;
      end
      dims_reg = NUM_DIMS_RESET;
      for (int i = 0; i < NUM_DIMS; i++) limit_reg[i] = LIMIT_W'(1);
      due_replies.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_DIMS) begin
          dims_reg = cfg_data[DIMS_W-1:0];
        end else if (cfg_index >= CFG_DIM_LIMIT_0 && cfg_index <= CFG_DIM_LIMIT_LAST) begin
          limit_reg[cfg_index - CFG_DIM_LIMIT_0] = cfg_data[LIMIT_W-1:0];
        end
      end
      if (m_tvalid && m_tready) begin
        if (due_replies.size() == 0) begin
          $display("%0t unexpected item: expected none, got %0h", $time, m_tdata);
          fail_count++;
        end else begin
          check_reply(due_replies.pop_front(), m_tdata);
        end
      end
      if (s_tvalid && s_tready) begin
        due_replies.insert(due_replies.size(),
                           map_item(s_tuser, s_tdata[NUM_DIMS*COORD_W-1:0],
                                    s_tdata[NUM_DIMS*COORD_W +: ID_W]));
      end
    end
    backlog <= due_replies.size();
  end

endmodule

### test/coordinate_id_bidirectional_map_unit_tb.sv
// Testbench top for the coordinate/id map unit: clock, reset, configuration,
// item stimulus and verdict. Depends on cidm_pkg and the checker module.
`timescale 1ns / 1ps
module coordinate_id_bidirectional_map_unit_tb;
  import cidm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 70;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // coord_0..coord_3, user_id
  logic [CMD_W-1:0]      s_tuser;   // command
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // found, id_out, loc_out_0..loc_out_3
  int                    backlog;
  int                    errors;

  bit                    gaps_on = 1'b0;
  bit                    throttle = 1'b0;
  bit                    hold_req = 1'b0;
  logic [LIMIT_W-1:0]    cur_limit [NUM_DIMS];
  coords_t               placed_coords [$];

  coordinate_id_bidirectional_map_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  coordinate_id_bidirectional_map_unit_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .backlog   (backlog),
    .errors    (errors)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAIL coordinate_id_bidirectional_map_unit");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic coords_t grid_point(input int c0, input int c1, input int c2,
                                         input int c3);
    return {COORD_W'(c3), COORD_W'(c2), COORD_W'(c1), COORD_W'(c0)};
  endfunction

  initial begin : result_sink
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!throttle) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b0;
        repeat (1 + pick_gap()) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input coords_t crd,
                           input logic [ID_W-1:0] uid);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {uid, crd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (backlog == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input int dims, input int l0, input int l1, input int l2,
                              input int l3);
    int lims [NUM_DIMS];
    int i;
    lims = '{l0, l1, l2, l3};
    cfg_we <= 1'b1;
    cfg_index <= CFG_NUM_DIMS;
    cfg_data <= CFG_DATA_W'(dims);
    @(posedge clk);
    for (i = 0; i < NUM_DIMS; i++) begin
      cfg_index <= CFG_DIM_LIMIT_0 + CFG_IDX_W'(i);
      cfg_data <= CFG_DATA_W'(lims[i]);
      cur_limit[i] = LIMIT_W'(lims[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int              k;
    int              i;
    int              r;
    int              span;
    coords_t         crd;
    logic [ID_W-1:0] uid;
    logic [CMD_W-1:0] cmd;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) cmd = CMD_INSERT;
      else if (r < 70) cmd = CMD_FIND_ID;
      else if (r < 95) cmd = CMD_FIND_COORDS;
      else cmd = CMD_RESERVED;
      r = $urandom_range(0, 99);
      if (r < 25 && placed_coords.size() > 0) begin
        crd = placed_coords[$urandom_range(0, placed_coords.size() - 1)];
      end else if (r < 80) begin
        for (i = 0; i < NUM_DIMS; i++) begin
          span = (cur_limit[i] > 1024) ? 1024 : int'(cur_limit[i]);
          crd[i] = (span == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, span - 1));
        end
      end else begin
        crd = coords_t'({$urandom, $urandom});
      end
      uid = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
      if (cmd == CMD_INSERT) begin
        placed_coords.insert(placed_coords.size(), crd);
        if (placed_coords.size() > 32) void'(placed_coords.pop_front());
      end
      send_item(cmd, crd, uid);
    end
  endtask

  initial begin : stimulus
    int phase;
    int r;
    int dims;
    int lims [NUM_DIMS];
    int i;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_NUM_DIMS;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_INSERT;
    for (i = 0; i < NUM_DIMS; i++) cur_limit[i] = LIMIT_W'(1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset setting: four dimensions of size one, a single location slot
    send_item(CMD_FIND_ID, grid_point(0, 0, 0, 0), 8'd0);
    send_item(CMD_FIND_COORDS, grid_point(0, 0, 0, 0), 8'd0);
    send_item(CMD_INSERT, grid_point(0, 0, 0, 0), 8'd255);
    send_item(CMD_INSERT, grid_point(1023, 1023, 1023, 1023), 8'd0);
    send_item(CMD_FIND_COORDS, grid_point(0, 0, 0, 0), 8'd0);
    send_item(CMD_FIND_ID, grid_point(0, 0, 0, 0), 8'd0);
    send_item(CMD_RESERVED, grid_point(1023, 1023, 1023, 1023), 8'd255);
    drain();

    // coordinates beyond their limit, and lookups under a narrower setting
    write_config(2, 32, 32, 1, 1);
    send_item(CMD_INSERT, grid_point(31, 31, 5, 9), 8'd7);
    send_item(CMD_INSERT, grid_point(32, 0, 0, 0), 8'd8);
    send_item(CMD_INSERT, grid_point(0, 40, 0, 0), 8'd9);
    send_item(CMD_FIND_ID, grid_point(31, 31, 1023, 1023), 8'd0);
    send_item(CMD_FIND_ID, grid_point(1, 8, 0, 0), 8'd0);
    send_item(CMD_FIND_COORDS, grid_point(0, 0, 0, 0), 8'd9);
    send_item(CMD_FIND_COORDS, grid_point(0, 0, 0, 0), 8'd0);
    drain();

    // zero dimensions count as one; an oversized limit clamps the capacity
    write_config(0, 2047, 1, 1, 1);
    send_item(CMD_INSERT, grid_point(1023, 3, 3, 3), 8'd200);
    send_item(CMD_FIND_ID, grid_point(1023, 0, 0, 0), 8'd0);
    send_item(CMD_INSERT, grid_point(5, 0, 0, 0), 8'd3);
    drain();

    // too many dimensions saturate; a zero limit leaves no slot at all
    write_config(7, 3, 3, 0, 5);
    send_item(CMD_INSERT, grid_point(1, 2, 3, 4), 8'd100);
    send_item(CMD_FIND_ID, grid_point(0, 0, 0, 0), 8'd0);
    send_item(CMD_FIND_COORDS, grid_point(0, 0, 0, 0), 8'd100);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin dims = 1; lims = '{1024, 1, 1, 1}; end
        1: begin dims = 4; lims = '{1024, 1024, 1024, 1024}; end
        2: begin dims = 2; lims = '{4, 4, 1, 1}; end
        3: begin dims = 3; lims = '{2, 3, 5, 1}; end
        4: begin dims = 1; lims = '{1, 1, 1, 1}; end
        default: begin
          r = $urandom_range(0, 99);
          dims = (r < 80) ? $urandom_range(1, 4) : ((r < 90) ? 0 : $urandom_range(5, 7));
          for (i = 0; i < NUM_DIMS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) lims[i] = 0;
            else if (r < 16) lims[i] = 1024;
            else if (r < 22) lims[i] = 2047;
            else if (r < 35) lims[i] = $urandom_range(1, 64);
            else lims[i] = $urandom_range(1, 8);
          end
        end
      endcase
      write_config(dims, lims[0], lims[1], lims[2], lims[3]);
      gaps_on = (phase % 3 != 0);
      throttle = (phase % 3 != 0) && ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      run_random(PHASE_ITEMS);
      drain();
    end

    if (errors == 0) begin
      $display("PASS coordinate_id_bidirectional_map_unit");
    end else begin
      $display("FAIL coordinate_id_bidirectional_map_unit");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/cidm_pkg.sv
hdl/cidm_cfg.sv
hdl/cidm_front.sv
hdl/cidm_queue.sv
hdl/cidm_back.sv
hdl/coordinate_id_bidirectional_map_unit.sv
test/coordinate_id_bidirectional_map_unit_checker.sv
test/coordinate_id_bidirectional_map_unit_tb.sv
